@@ rtl/core/mrsd_pkg.sv @@
// shared types and constants for the bzip2 mtf / run symbol decoder
package mrsd_pkg;

  localparam int ALPHABET_DEF = 256;
  localparam int RUN_BITS_DEF = 20;

  localparam int BYTE_W    = 8;
  localparam int SYM_W     = 9;
  localparam int CNT_W     = 20;
  localparam int LEN_W     = 20;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MAP_REGS  = 4;
  localparam int MAP_CNT_W = 7;

  localparam logic [LEN_W-1:0] CAPACITY_RST = LEN_W'(900000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_USE_0   = 3'd0,
    REG_IN_USE_1   = 3'd1,
    REG_IN_USE_2   = 3'd2,
    REG_IN_USE_3   = 3'd3,
    REG_CAPACITY   = 3'd4
  } cfg_reg_t;

  // one result as it waits for the output side
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  repeat_count;
    logic              end_of_block;
    logic              block_error;
    logic              last;
  } res_t;

  // control broadcast to every list cell
  typedef struct packed {
    logic clear;
    logic move;
    logic push;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic room;
  } fifo_stat_t;

endpackage

@@ rtl/core/mrsd_cell.sv @@
// one entry of the move-to-front list
module mrsd_cell #(
  parameter int ALPHABET = mrsd_pkg::ALPHABET_DEF,
  parameter int INDEX    = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrsd_pkg::cell_ctrl_t            ctrl,
  input  logic [$clog2(ALPHABET)-1:0]     pos,
  input  logic [mrsd_pkg::BYTE_W-1:0]     prev_val,
  output logic [mrsd_pkg::BYTE_W-1:0]     val,
  output logic [mrsd_pkg::BYTE_W-1:0]     hit_val
);
  import mrsd_pkg::*;

  localparam int PW = $clog2(ALPHABET);
  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic [BYTE_W-1:0] val_r;
  logic [BYTE_W-1:0] val_nxt;
  logic              take;

  // on a move, cells at or in front of the selected position shift back by one; on a push, every cell does
  assign take = ctrl.push | (ctrl.move & (pos >= IDX));

  always_comb begin
    val_nxt = val_r;
    if (ctrl.clear) begin
      val_nxt = '0;
    end else if (take) begin
      val_nxt = prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val     = val_r;
  assign hit_val = (pos == IDX) ? val_r : '0;

endmodule

@@ rtl/core/mrsd_res_fifo.sv @@
// four-entry result queue, up to two writes and one read per cycle; reads wait on rd_ready
module mrsd_res_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           wr_cnt,
  input  mrsd_pkg::res_t       wr_a,
  input  mrsd_pkg::res_t       wr_b,
  input  logic                 rd_ready,
  output mrsd_pkg::res_t       rd_data,
  output mrsd_pkg::fifo_stat_t stat
);
  import mrsd_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  res_t          q_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign pop        = (cnt_r != '0) & rd_ready;
  assign wr_ptr_p1  = wr_ptr_r + AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + AW'(wr_cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + CW'(wr_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      q_r[wr_ptr_r] <= wr_a;
    end
    if (wr_cnt == 2'd2) begin
      q_r[wr_ptr_p1] <= wr_b;
    end
  end

  assign rd_data    = q_r[rd_ptr_r];
  assign stat.valid = (cnt_r != '0);
  // room for the two results a single request can cause
  assign stat.room  = (cnt_r <= CW'(DEPTH - 2));

endmodule

@@ rtl/core/mtf_run_symbol_decoder_core.sv @@
// top level of the bzip2 mtf / runa-runb symbol decoder
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready     in_symbol
//  out_     output     out_valid / out_ready   out_byte, out_repeat_count, out_end_of_block,
//                                              out_block_error, out_last
//  cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// one symbol request per cycle while in_ready is high; the cells up to the selected position shift in that cycle
// results leave a four-entry queue one per cycle while out_ready is high; a request needs room for two
// an end-of-block request is followed by a rebuild that scans the
// bitmap one byte per cycle and pushes used bytes into the front cell
// synchronous reset clears the list, run state and queue; reset does not start a rebuild
// out_ready low fills the queue and then holds in_ready low
module mtf_run_symbol_decoder_core #(
  parameter int ALPHABET = mrsd_pkg::ALPHABET_DEF,
  parameter int RUN_BITS = mrsd_pkg::RUN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mrsd_pkg::SYM_W-1:0]        in_symbol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrsd_pkg::BYTE_W-1:0]       out_byte,
  output logic [mrsd_pkg::CNT_W-1:0]        out_repeat_count,
  output logic                              out_end_of_block,
  output logic                              out_block_error,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [mrsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrsd_pkg::CFG_W-1:0]        cfg_wdata
);
  import mrsd_pkg::*;

  localparam int PW    = $clog2(ALPHABET);
  localparam int SUM_W = ((RUN_BITS > LEN_W) ? RUN_BITS : LEN_W) + 1;
  localparam int MAP_W = MAP_REGS * CFG_W;
  localparam logic [MAP_W-1:0] ALPHA_MASK = {MAP_W{1'b1}} >> (MAP_W - ALPHABET);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_BUILD = 2'b10
  } state_t;

  // popcount as eight byte counts and a sum of them
  function automatic logic [MAP_CNT_W-1:0] pop64(input logic [CFG_W-1:0] v);
    logic [3:0]           part [8];
    logic [MAP_CNT_W-1:0] tot;
    for (int b = 0; b < 8; b++) begin
      part[b] = '0;
      for (int i = 0; i < 8; i++) begin
        part[b] = part[b] + 4'(v[8*b+i]);
      end
    end
    tot = '0;
    for (int b = 0; b < 8; b++) begin
      tot = tot + MAP_CNT_W'(part[b]);
    end
    return tot;
  endfunction

  // configuration
  logic [CFG_W-1:0]     in_use_r   [MAP_REGS];
  logic [MAP_CNT_W-1:0] used_cnt_r [MAP_REGS];
  logic [LEN_W-1:0]     capacity_r;
  logic [MAP_W-1:0]     map_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAP_REGS; r++) begin
        in_use_r[r]   <= '0;
        used_cnt_r[r] <= '0;
      end
      capacity_r <= CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_USE_0: begin
          in_use_r[0]   <= cfg_wdata;
          used_cnt_r[0] <= pop64(cfg_wdata & ALPHA_MASK[0*CFG_W +: CFG_W]);
        end
        REG_IN_USE_1: begin
          in_use_r[1]   <= cfg_wdata;
          used_cnt_r[1] <= pop64(cfg_wdata & ALPHA_MASK[1*CFG_W +: CFG_W]);
        end
        REG_IN_USE_2: begin
          in_use_r[2]   <= cfg_wdata;
          used_cnt_r[2] <= pop64(cfg_wdata & ALPHA_MASK[2*CFG_W +: CFG_W]);
        end
        REG_IN_USE_3: begin
          in_use_r[3]   <= cfg_wdata;
          used_cnt_r[3] <= pop64(cfg_wdata & ALPHA_MASK[3*CFG_W +: CFG_W]);
        end
        REG_CAPACITY: begin
          capacity_r <= cfg_wdata[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign map_bits = {in_use_r[3], in_use_r[2], in_use_r[1], in_use_r[0]};

  // symbol decode
  logic [SYM_W-1:0] n_used, eob_sym;
  logic             is_eob, is_run, is_bad, is_mtf, accept;
  logic [PW-1:0]    pos;

  assign n_used  = SYM_W'(used_cnt_r[0]) + SYM_W'(used_cnt_r[1])
                 + SYM_W'(used_cnt_r[2]) + SYM_W'(used_cnt_r[3]);
  assign eob_sym = n_used + SYM_W'(1);
  assign is_eob  = (in_symbol == eob_sym);
  assign is_run  = !is_eob && (in_symbol <= SYM_W'(1));
  assign is_bad  = (in_symbol > eob_sym);
  assign is_mtf  = !is_eob && !is_run && !is_bad;
  assign pos     = PW'(in_symbol - SYM_W'(1));

  // state
  state_t              state_r, state_nxt;
  logic [ALPHABET-1:0] build_bits_r, build_bits_nxt;
  logic [PW-1:0]       build_idx_r, build_idx_nxt;
  logic [RUN_BITS-1:0] run_sum_r, run_sum_nxt;
  logic [RUN_BITS:0]   run_w_r, run_w_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                bad_r, bad_nxt;
  fifo_stat_t          fstat;

  assign in_ready = (state_r == ST_RUN) && fstat.room;
  assign accept   = in_valid && in_ready;

  // cell chain
  cell_ctrl_t           ctrl;
  logic [BYTE_W-1:0]    cell_val  [ALPHABET];
  logic [BYTE_W-1:0]    cell_hit  [ALPHABET];
  logic [BYTE_W-1:0]    cell_prev [ALPHABET];
  logic [BYTE_W-1:0]    sel_byte, build_byte, head_in;
  logic [PW+BYTE_W-1:0] idx_wide;

  assign ctrl.clear = accept && is_eob;
  assign ctrl.move  = accept && is_mtf;
  assign ctrl.push  = (state_r == ST_BUILD) && build_bits_r[ALPHABET-1];

  assign idx_wide   = {{BYTE_W{1'b0}}, build_idx_r};
  assign build_byte = idx_wide[BYTE_W-1:0];
  assign head_in    = ctrl.push ? build_byte : sel_byte;

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      sel_byte = sel_byte | cell_hit[i];
    end
  end

  for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_prev[g] = head_in;
    end else begin : g_body
      assign cell_prev[g] = cell_val[g-1];
    end
    mrsd_cell #(
      .ALPHABET (ALPHABET),
      .INDEX    (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pos      (pos),
      .prev_val (cell_prev[g]),
      .val      (cell_val[g]),
      .hit_val  (cell_hit[g])
    );
  end

  // run and length arithmetic
  logic                flush, has_main, blk_err;
  logic [RUN_BITS+1:0] run_add;
  logic [SUM_W-1:0]    len_sum;
  logic [LEN_W-1:0]    len_run, len_mtf;
  logic [LEN_W:0]      len_inc;

  assign flush    = |run_w_r[RUN_BITS:1];
  assign has_main = is_eob || is_mtf;
  assign run_add  = (RUN_BITS+2)'(run_sum_r) + ((RUN_BITS+2)'(run_w_r) << in_symbol[0]);
  assign len_sum  = SUM_W'(len_r) + SUM_W'(run_sum_r);

  always_comb begin
    if (!flush) begin
      len_run = len_r;
    end else if (len_sum > SUM_W'({LEN_W{1'b1}})) begin
      len_run = {LEN_W{1'b1}};
    end else begin
      len_run = len_sum[LEN_W-1:0];
    end
  end

  assign len_inc = {1'b0, len_run} + (LEN_W+1)'(1);
  assign len_mtf = len_inc[LEN_W] ? {LEN_W{1'b1}} : len_inc[LEN_W-1:0];
  assign blk_err = (len_run >= capacity_r) || bad_r;

  always_comb begin
    state_nxt      = state_r;
    build_bits_nxt = build_bits_r;
    build_idx_nxt  = build_idx_r;
    run_sum_nxt    = run_sum_r;
    run_w_nxt      = run_w_r;
    len_nxt        = len_r;
    bad_nxt        = bad_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (is_run) begin
            run_sum_nxt = (|run_add[RUN_BITS+1:RUN_BITS]) ? {RUN_BITS{1'b1}}
                                                          : run_add[RUN_BITS-1:0];
            // weight is a power of two and sticks at its top
            run_w_nxt   = run_w_r[RUN_BITS] ? run_w_r : {run_w_r[RUN_BITS-1:0], 1'b0};
          end else begin
            run_sum_nxt = '0;
            run_w_nxt   = (RUN_BITS+1)'(1);
            if (is_eob) begin
              len_nxt        = '0;
              bad_nxt        = 1'b0;
              build_bits_nxt = map_bits[ALPHABET-1:0];
              build_idx_nxt  = PW'(ALPHABET - 1);
              state_nxt      = ST_BUILD;
            end else if (is_bad) begin
              len_nxt = len_run;
              bad_nxt = 1'b1;
            end else begin
              len_nxt = len_mtf;
            end
          end
        end
      end
      ST_BUILD: begin
        // scan from the top byte down so the smallest ends in front
        build_bits_nxt = build_bits_r << 1;
        build_idx_nxt  = build_idx_r - PW'(1);
        if (build_idx_r == '0) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      build_bits_r <= '0;
      build_idx_r  <= '0;
      run_sum_r    <= '0;
      run_w_r      <= (RUN_BITS+1)'(1);
      len_r        <= '0;
      bad_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      build_bits_r <= build_bits_nxt;
      build_idx_r  <= build_idx_nxt;
      run_sum_r    <= run_sum_nxt;
      run_w_r      <= run_w_nxt;
      len_r        <= len_nxt;
      bad_r        <= bad_nxt;
    end
  end

  // results
  res_t       res_run, res_main, wr_a, rd_data;
  logic [1:0] wr_cnt;

  always_comb begin
    res_run.out_byte     = cell_val[0];
    res_run.repeat_count = CNT_W'(run_sum_r);
    res_run.end_of_block = 1'b0;
    res_run.block_error  = 1'b0;
    res_run.last         = !has_main;

    res_main.last = 1'b1;
    if (is_eob) begin
      res_main.out_byte     = '0;
      res_main.repeat_count = '0;
      res_main.end_of_block = 1'b1;
      res_main.block_error  = blk_err;
    end else begin
      res_main.out_byte     = sel_byte;
      res_main.repeat_count = CNT_W'(1);
      res_main.end_of_block = 1'b0;
      res_main.block_error  = 1'b0;
    end
  end

  assign wr_a   = flush ? res_run : res_main;
  assign wr_cnt = (accept && !is_run) ? {flush && has_main, flush ^ has_main} : 2'd0;

  mrsd_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_a     (wr_a),
    .wr_b     (res_main),
    .rd_ready (out_ready),
    .rd_data  (rd_data),
    .stat     (fstat)
  );

  assign out_valid        = fstat.valid;
  assign out_byte         = rd_data.out_byte;
  assign out_repeat_count = rd_data.repeat_count;
  assign out_end_of_block = rd_data.end_of_block;
  assign out_block_error  = rd_data.block_error;
  assign out_last         = rd_data.last;

  // checks
  a_eob_builds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_eob) |=> (state_r == ST_BUILD))
    else $error("end of block did not start a list rebuild");

  a_weight_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(run_w_r))
    else $error("run weight is not a power of two");

  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_run) |=> (run_w_r == (RUN_BITS+1)'(1)) && (run_sum_r == '0))
    else $error("pending run not cleared after a non-run symbol");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

endmodule
